// ===== hw/rtl/mwmt_pkg.sv =====
// Shared constants and types for the maze wall map tracker.
package mwmt_pkg;

    localparam int GRID_WIDTH  = 16;
    localparam int GRID_HEIGHT = 16;

    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PW     = (XW > YW) ? XW : YW;
    // wide enough for a coordinate plus a 4-bit step count
    localparam int CW     = ((PW > 4) ? PW : 4) + 1;

    localparam logic [2:0] CMD_MOVE  = 3'd0;
    localparam logic [2:0] CMD_TURN  = 3'd1;
    localparam logic [2:0] CMD_SENSE = 3'd2;
    localparam logic [2:0] CMD_QUERY = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [1:0] MARK_OPEN    = 2'd0;
    localparam logic [7:0] WORD_UNKNOWN = 8'hAA;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 16;

    // output bit positions inside m_tdata
    localparam int OUT_INTER_BIT = 10;
    localparam int OUT_OFF_BIT   = 11;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] step_count;
        logic       turn_right;
        logic       wall_left;
        logic       wall_front;
        logic       wall_right;
        logic [3:0] query_x;
        logic [3:0] query_y;
    } cmd_t;

endpackage

// ===== hw/rtl/maze_wall_map_tracker.sv =====
// Robot pose tracker with a per-cell wall map held in a synchronous memory.
//
//  channel | direction | ports                        | content
//  --------+-----------+------------------------------+------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata    | one robot command per
//          |           | s_tuser                      | transaction
//  m_      | out       | m_tvalid m_tready m_tdata    | pose and flags after the command
//
// Each command is accepted in ST_IDLE, where the map read is issued; ST_BUSY then
// modifies, writes back and loads the output register. A stalled output holds
// ST_BUSY until the output register frees; a new command is accepted while a
// result waits.
// Reset and the clear command both invalidate all cells together through per-cell
// valid bits; an invalid cell reads as all marks unknown.
module maze_wall_map_tracker
    import mwmt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // step_count[3:0], turn_right[4], wall_left[5], wall_front[6], wall_right[7],
    // query_x[11:8], query_y[15:12]
    input  logic [S_DATA_W-1:0] s_tdata,
    // command[2:0]
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pos_x[3:0], pos_y[7:4], heading[9:8], is_intersection[10], off_maze[11],
    // zero[15:12]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg, state_next;

    cmd_t cmd_in;
    cmd_t cmd_reg;

    logic [XW-1:0] robot_x_reg, robot_x_next;
    logic [YW-1:0] robot_y_reg, robot_y_next;
    logic [1:0]    heading_reg, heading_next;

    logic [7:0]       map_mem [CELLS];
    logic [CELLS-1:0] map_vld_reg;
    logic [7:0]       rd_word_reg;
    logic             rd_vld_reg;

    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_valid_reg;

    logic              s_fire;
    logic              done;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        map_word;
    logic [7:0]        sense_word;
    logic [3:0]        mark_sum;
    logic              q_in_grid;
    logic              inter;
    logic              clipped;

    logic          mv_up;
    logic          mv_on_x;
    logic [CW-1:0] mv_pos;
    logic [CW-1:0] mv_step;
    logic [CW-1:0] mv_limit;
    logic [CW-1:0] mv_res;

    assign cmd_in = {s_tuser[2:0], s_tdata[3:0], s_tdata[4], s_tdata[5], s_tdata[6],
                     s_tdata[7], s_tdata[11:8], s_tdata[15:12]};

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign done     = (state_reg == ST_BUSY) && (!out_valid_reg || m_tready);

    assign rd_addr = ADDR_W'(int'(cmd_in.query_y) * GRID_WIDTH + int'(cmd_in.query_x));
    assign wr_addr = ADDR_W'(int'(robot_y_reg) * GRID_WIDTH + int'(robot_x_reg));

    // map read at accept; write back at completion, so the next read always
    // sees the last write
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_word_reg <= map_mem[rd_addr];
            rd_vld_reg  <= map_vld_reg[rd_addr];
        end
        if (done && cmd_reg.command == CMD_SENSE) begin
            map_mem[wr_addr] <= sense_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_vld_reg <= '0;
        end else if (done && cmd_reg.command == CMD_CLEAR) begin
            map_vld_reg <= '0;
        end else if (done && cmd_reg.command == CMD_SENSE) begin
            map_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= cmd_in;
        end
    end

    // sensor marks rotated by heading; rear side open
    always_comb begin
        logic [1:0] rel;
        for (int s = 0; s < 4; s++) begin
            rel = 2'(s) - heading_reg;
            case (rel)
                2'd0:    sense_word[2*s +: 2] = {1'b0, cmd_reg.wall_front};
                2'd1:    sense_word[2*s +: 2] = {1'b0, cmd_reg.wall_right};
                2'd3:    sense_word[2*s +: 2] = {1'b0, cmd_reg.wall_left};
                default: sense_word[2*s +: 2] = MARK_OPEN;
            endcase
        end
    end

    assign map_word  = rd_vld_reg ? rd_word_reg : WORD_UNKNOWN;
    assign mark_sum  = 4'(map_word[1:0]) + 4'(map_word[3:2])
                     + 4'(map_word[5:4]) + 4'(map_word[7:6]);
    assign q_in_grid = (int'(cmd_reg.query_x) < GRID_WIDTH)
                    && (int'(cmd_reg.query_y) < GRID_HEIGHT);
    assign inter     = (cmd_reg.command == CMD_QUERY) && q_in_grid && (mark_sum < 4'd2);

    // saturating advance along the heading: north +y, east +x, south -y, west -x
    always_comb begin
        mv_on_x  = heading_reg[0];
        mv_up    = !heading_reg[1];
        mv_pos   = mv_on_x ? CW'(robot_x_reg) : CW'(robot_y_reg);
        mv_step  = CW'(cmd_reg.step_count);
        mv_limit = mv_on_x ? CW'(GRID_WIDTH - 1) : CW'(GRID_HEIGHT - 1);
        clipped  = 1'b0;
        if (mv_up) begin
            if (mv_pos + mv_step > mv_limit) begin
                clipped = 1'b1;
                mv_res  = mv_limit;
            end else begin
                mv_res  = mv_pos + mv_step;
            end
        end else begin
            if (mv_step > mv_pos) begin
                clipped = 1'b1;
                mv_res  = '0;
            end else begin
                mv_res  = mv_pos - mv_step;
            end
        end
    end

    always_comb begin
        robot_x_next = robot_x_reg;
        robot_y_next = robot_y_reg;
        heading_next = heading_reg;
        case (cmd_reg.command)
            CMD_MOVE: begin
                if (mv_on_x) begin
                    robot_x_next = XW'(mv_res);
                end else begin
                    robot_y_next = YW'(mv_res);
                end
            end
            CMD_TURN: begin
                heading_next = heading_reg + (cmd_reg.turn_right ? 2'd1 : 2'd3);
            end
            default: begin
            end
        endcase
    end

    assign out_data_next = {4'b0000,
                            (cmd_reg.command == CMD_MOVE) && clipped,
                            inter,
                            heading_next,
                            4'(robot_y_next),
                            4'(robot_x_next)};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_BUSY;
            ST_BUSY: if (done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (done) begin
                robot_x_reg   <= robot_x_next;
                robot_y_reg   <= robot_y_next;
                heading_reg   <= heading_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_done_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (state_reg == ST_IDLE) && m_tvalid)
        else $error("completed command did not load the output register");

    a_heading_only_on_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        !(done && cmd_reg.command == CMD_TURN) |=> $stable(heading_reg))
        else $error("heading changed without a turn command");

    a_off_only_on_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && cmd_reg.command != CMD_MOVE) |=> !m_tdata[OUT_OFF_BIT])
        else $error("off_maze flagged for a command other than move");

    a_pose_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(robot_x_reg) < GRID_WIDTH) && (int'(robot_y_reg) < GRID_HEIGHT))
        else $error("robot pose left the grid");
`endif

endmodule
